// File: rtl/core/pswg_pkg.sv
package pswg_pkg;

	// sample and store geometry
	localparam int SAMPLE_W = 16;
	localparam int MAX_DELAY = 4096;
	localparam int ADDR_W = $clog2(MAX_DELAY);
	localparam int LEN_W = ADDR_W + 1;

	// register widths
	localparam int GAIN_W = 17;
	localparam int PICK_W = 29;
	localparam int BODY_W = 15;
	localparam int FRAC_W = 16;
	localparam int OI_W = PICK_W - FRAC_W;
	localparam int AP_W = 18;

	// stream and config ports
	localparam int IN_POS_W = 12;
	localparam int IN_DATA_W = 32;
	localparam int IN_USED_W = IN_POS_W + SAMPLE_W;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 29;

	// shared multiplier
	localparam int MA_W = 34;
	localparam int MB_W = 18;
	localparam int PROD_W = MA_W + MB_W;
	localparam int RND_W = PROD_W - FRAC_W + 1;

	localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(4);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DELAY);
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(100);
	localparam logic [GAIN_W-1:0] Q_ONE = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0] DECAY_RESET = GAIN_W'(65503);
	localparam logic [BODY_W-1:0] BODY_MAX = BODY_W'(19661);
	localparam logic [PICK_W-1:0] PICK_MAX = PICK_W'(268435456);

	localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_LENGTH = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_DECAY_GAIN = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_DAMPING_COEF = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_ALLPASS_COEF = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_PICKUP_OFFSET = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_BODY_GAIN = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_GAIN = 3'd6;

	localparam logic ACTION_LOAD = 1'b1;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_CAPTURE,
		OP_LOAD,
		OP_READ_X,
		OP_DAMP_MUL,
		OP_DAMP,
		OP_DECAY_MUL,
		OP_DECAY,
		OP_AP1_MUL,
		OP_AP1,
		OP_AP2_MUL,
		OP_AP2,
		OP_WRITE,
		OP_READ_P1,
		OP_READ_P2,
		OP_READ_B,
		OP_PICK_MUL,
		OP_PICK,
		OP_BODY_MUL,
		OP_SUM,
		OP_OUT_MUL,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_READ_X,
		ST_DAMP_MUL,
		ST_DAMP,
		ST_DECAY_MUL,
		ST_DECAY,
		ST_AP1_MUL,
		ST_AP1,
		ST_AP2_MUL,
		ST_AP2,
		ST_WRITE,
		ST_READ_P1,
		ST_READ_P2,
		ST_READ_B,
		ST_PICK_MUL,
		ST_PICK,
		ST_BODY_MUL,
		ST_SUM,
		ST_OUT_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clear_last;
		logic rem_done;
		logic ap_on;
		logic out_free;
	} dp_status_t;

endpackage

// File: rtl/core/pswg_rem.sv
module pswg_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pswg_pkg::OI_W-1:0]     dividend,
	input  logic [pswg_pkg::LEN_W-1:0]    divisor,
	output logic [pswg_pkg::LEN_W-1:0]    remainder,
	output logic                          done
);
	import pswg_pkg::*;

	localparam int CNT_W = $clog2(OI_W + 1);

	logic [LEN_W-1:0] rem_q;
	logic [OI_W-1:0]  num_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [LEN_W:0]   shifted;
	logic [LEN_W:0]   trial;

	// restoring remainder, one dividend bit per cycle
	assign shifted = {rem_q, num_q[OI_W-1]};
	assign trial = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CNT_W'(OI_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
		end else if (cnt_q != '0) begin
			num_q <= num_q << 1;
			rem_q <= trial[LEN_W] ? shifted[LEN_W-1:0] : trial[LEN_W-1:0];
		end
	end

	assign remainder = rem_q;
	assign done = done_q;

endmodule

// File: rtl/core/pswg_dpath.sv
module pswg_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pswg_pkg::op_t                         op,
	input  logic [pswg_pkg::IN_USED_W-1:0]        in_data,
	input  logic                                  cfg_we,
	input  logic [pswg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [pswg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic [pswg_pkg::SAMPLE_W-1:0]         out_sample,
	output pswg_pkg::dp_status_t                  status
);
	import pswg_pkg::*;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
		if (v < LEN_MIN) begin
			return LEN_MIN;
		end
		if (v > LEN_MAX) begin
			return LEN_MAX;
		end
		return v;
	endfunction

	function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
		return (v > Q_ONE) ? Q_ONE : v;
	endfunction

	function automatic logic signed [RND_W-2:0] rnd16(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + PROD_W'(32768);
		return t[PROD_W-1:FRAC_W];
	endfunction

	function automatic logic signed [PROD_W-33:0] rnd32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + (PROD_W'(1) << 31);
		return t[PROD_W-1:32];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [RND_W-1:0] v);
		if (&v[RND_W-1:SAMPLE_W-1] || ~|v[RND_W-1:SAMPLE_W-1]) begin
			return v[SAMPLE_W-1:0];
		end
		return v[RND_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
	endfunction

	function automatic logic signed [AP_W-1:0] sat_ap(input logic signed [RND_W-1:0] v);
		if (&v[RND_W-1:AP_W-1] || ~|v[RND_W-1:AP_W-1]) begin
			return v[AP_W-1:0];
		end
		return v[RND_W-1] ? {1'b1, {(AP_W-1){1'b0}}} : {1'b0, {(AP_W-1){1'b1}}};
	endfunction

	// settings, all but the pickup offset clamped
	logic [LEN_W-1:0]  len_q;
	logic [GAIN_W-1:0] decay_q;
	logic [GAIN_W-1:0] damp_q;
	logic [GAIN_W-1:0] ap_q;
	logic [PICK_W-1:0] pick_off_q;
	logic [BODY_W-1:0] body_q;
	logic [GAIN_W-1:0] outg_q;

	// loop state
	logic [ADDR_W-1:0]          wp_q;
	logic signed [SAMPLE_W-1:0] dm_q;
	logic signed [AP_W-1:0]     apm_q;
	logic [ADDR_W-1:0]          clr_q;
	logic                       out_valid_q;

	// working registers
	logic [ADDR_W-1:0]          load_pos_q;
	logic signed [SAMPLE_W-1:0] exc_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic signed [PROD_W-1:0]   p_q;
	logic signed [SAMPLE_W-1:0] dec_q;
	logic signed [AP_W-1:0]     v_q;
	logic [ADDR_W-1:0]          p1_q;
	logic [ADDR_W-1:0]          p2_q;
	logic [ADDR_W-1:0]          b_q;
	logic signed [SAMPLE_W-1:0] s1_q;
	logic signed [SAMPLE_W-1:0] s2_q;
	logic signed [SAMPLE_W-1:0] pick_q;
	logic signed [MA_W-1:0]     sum_q;
	logic signed [SAMPLE_W-1:0] out_q;

	logic signed [SAMPLE_W-1:0] store_q [MAX_DELAY];

	logic                       mem_we;
	logic                       mem_re;
	logic [ADDR_W-1:0]          mem_wa;
	logic [ADDR_W-1:0]          mem_ra;
	logic signed [SAMPLE_W-1:0] mem_wd;

	logic signed [MA_W-1:0]     ma;
	logic signed [MB_W-1:0]     mb;
	logic signed [PROD_W-1:0]   prod;
	logic signed [SAMPLE_W:0]   damp_diff;
	logic signed [SAMPLE_W:0]   pick_diff;

	logic [ADDR_W-1:0]          wp_eff;
	logic [LEN_W:0]             p1_sum;
	logic [LEN_W:0]             b_sum;
	logic [LEN_W-1:0]           p1_inc;
	logic [LEN_W-1:0]           wp_inc;
	logic [ADDR_W-1:0]          p1_next;
	logic [ADDR_W-1:0]          b_next;
	logic [ADDR_W-1:0]          p2_next;
	logic [ADDR_W-1:0]          wp_next;
	logic [LEN_W-1:0]           rem;
	logic                       rem_done;

	pswg_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (op == OP_READ_X),
		.dividend  (pick_off_q[PICK_W-1:FRAC_W]),
		.divisor   (len_q),
		.remainder (rem),
		.done      (rem_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
			decay_q <= DECAY_RESET;
			damp_q <= '0;
			ap_q <= '0;
			pick_off_q <= '0;
			body_q <= '0;
			outg_q <= Q_ONE;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_DELAY_LENGTH: len_q <= clamp_len(cfg_wdata[LEN_W-1:0]);
				CFG_DECAY_GAIN: decay_q <= clamp_gain(cfg_wdata[GAIN_W-1:0]);
				CFG_DAMPING_COEF: damp_q <= clamp_gain(cfg_wdata[GAIN_W-1:0]);
				CFG_ALLPASS_COEF: ap_q <= clamp_gain(cfg_wdata[GAIN_W-1:0]);
				// full 29-bit offset, the integer part wraps through the modulo
				CFG_PICKUP_OFFSET: pick_off_q <= cfg_wdata;
				CFG_BODY_GAIN: begin
					body_q <= (cfg_wdata[BODY_W-1:0] > BODY_MAX) ? BODY_MAX
						: cfg_wdata[BODY_W-1:0];
				end
				CFG_OUTPUT_GAIN: outg_q <= clamp_gain(cfg_wdata[GAIN_W-1:0]);
				default: ;
			endcase
		end
	end

	// pointer arithmetic, every sum stays below twice the length
	assign wp_eff = ({1'b0, wp_q} >= len_q) ? '0 : wp_q;
	assign p1_sum = (LEN_W+1)'(wp_q) + (LEN_W+1)'(rem);
	assign b_sum = (LEN_W+1)'(wp_q) + (LEN_W+1)'(len_q - (len_q >> 1));
	assign p1_next = (p1_sum >= (LEN_W+1)'(len_q))
		? ADDR_W'(p1_sum - (LEN_W+1)'(len_q)) : p1_sum[ADDR_W-1:0];
	assign b_next = (b_sum >= (LEN_W+1)'(len_q))
		? ADDR_W'(b_sum - (LEN_W+1)'(len_q)) : b_sum[ADDR_W-1:0];
	assign p1_inc = LEN_W'(p1_q) + LEN_W'(1);
	assign wp_inc = LEN_W'(wp_q) + LEN_W'(1);
	assign p2_next = (p1_inc == len_q) ? '0 : p1_inc[ADDR_W-1:0];
	assign wp_next = (wp_inc == len_q) ? '0 : wp_inc[ADDR_W-1:0];

	// shared multiplier operands
	assign damp_diff = (SAMPLE_W+1)'(dm_q) - (SAMPLE_W+1)'(rd_q);
	assign pick_diff = (SAMPLE_W+1)'(s2_q) - (SAMPLE_W+1)'(s1_q);

	always_comb begin
		ma = '0;
		mb = '0;
		case (op)
			OP_DAMP_MUL: begin
				ma = MA_W'(damp_diff);
				mb = {1'b0, damp_q};
			end
			OP_DECAY_MUL: begin
				ma = MA_W'(dm_q);
				mb = {1'b0, decay_q};
			end
			OP_AP1_MUL: begin
				ma = MA_W'(apm_q);
				mb = {1'b0, ap_q};
			end
			OP_AP2_MUL: begin
				ma = MA_W'(v_q);
				mb = {1'b0, ap_q};
			end
			OP_PICK_MUL: begin
				ma = MA_W'(pick_diff);
				mb = {2'b00, pick_off_q[FRAC_W-1:0]};
			end
			OP_BODY_MUL: begin
				ma = MA_W'(rd_q);
				mb = {3'b000, body_q};
			end
			OP_OUT_MUL: begin
				ma = sum_q;
				mb = {1'b0, outg_q};
			end
			default: ;
		endcase
	end

	assign prod = ma * mb;

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = wp_q;
		mem_wd = dec_q;
		mem_ra = wp_eff;
		case (op)
			OP_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			OP_LOAD: begin
				mem_we = 1'b1;
				mem_wa = load_pos_q;
				mem_wd = exc_q;
			end
			OP_WRITE: mem_we = 1'b1;
			OP_READ_X: mem_re = 1'b1;
			OP_READ_P1: begin
				mem_re = 1'b1;
				mem_ra = p1_q;
			end
			OP_READ_P2: begin
				mem_re = 1'b1;
				mem_ra = p2_q;
			end
			OP_READ_B: begin
				mem_re = 1'b1;
				mem_ra = b_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= store_q[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			dm_q <= '0;
			apm_q <= '0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (op)
				OP_CLEAR: clr_q <= clr_q + ADDR_W'(1);
				OP_LOAD: wp_q <= '0;
				OP_READ_X: wp_q <= wp_eff;
				OP_DAMP: begin
					dm_q <= sat_sample(RND_W'(rnd16((PROD_W'(rd_q) <<< FRAC_W) + p_q)));
				end
				OP_AP2: apm_q <= v_q;
				OP_OUT: wp_q <= wp_next;
				default: ;
			endcase
			if (op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_CAPTURE: begin
				load_pos_q <= in_data[IN_POS_W-1:0];
				exc_q <= in_data[IN_USED_W-1:IN_POS_W];
			end
			OP_DAMP_MUL, OP_DECAY_MUL, OP_AP1_MUL, OP_AP2_MUL,
			OP_PICK_MUL, OP_BODY_MUL, OP_OUT_MUL: p_q <= prod;
			OP_DECAY: dec_q <= sat_sample(RND_W'(rnd16(p_q)));
			OP_AP1: v_q <= sat_ap(RND_W'(dec_q) - RND_W'(rnd16(p_q)));
			OP_AP2: dec_q <= sat_sample(RND_W'(apm_q) + RND_W'(rnd16(p_q)));
			OP_WRITE: begin
				p1_q <= p1_next;
				b_q <= b_next;
			end
			OP_READ_P1: p2_q <= p2_next;
			OP_READ_P2: s1_q <= rd_q;
			OP_READ_B: s2_q <= rd_q;
			OP_PICK: begin
				pick_q <= sat_sample(RND_W'(rnd16((PROD_W'(s1_q) <<< FRAC_W) + p_q)));
			end
			OP_SUM: sum_q <= MA_W'((PROD_W'(pick_q) <<< FRAC_W) + p_q);
			OP_OUT: out_q <= sat_sample(RND_W'(rnd32(p_q)));
			default: ;
		endcase
	end

	assign status.clear_last = (clr_q == ADDR_W'(MAX_DELAY - 1));
	assign status.rem_done = rem_done;
	assign status.ap_on = (ap_q != '0);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_sample = out_q;

endmodule

// File: rtl/core/pswg_ctrl.sv
module pswg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_action,
	input  pswg_pkg::dp_status_t  status,
	output logic                  in_ready,
	output pswg_pkg::op_t         op
);
	import pswg_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_next = (in_action == ACTION_LOAD) ? ST_LOAD : ST_READ_X;
				end
			end
			ST_LOAD: state_next = ST_IDLE;
			ST_READ_X: state_next = ST_DAMP_MUL;
			ST_DAMP_MUL: state_next = ST_DAMP;
			ST_DAMP: state_next = ST_DECAY_MUL;
			ST_DECAY_MUL: state_next = ST_DECAY;
			ST_DECAY: state_next = status.ap_on ? ST_AP1_MUL : ST_WRITE;
			ST_AP1_MUL: state_next = ST_AP1;
			ST_AP1: state_next = ST_AP2_MUL;
			ST_AP2_MUL: state_next = ST_AP2;
			ST_AP2: state_next = ST_WRITE;
			// hold until the pickup offset modulo is ready
			ST_WRITE: begin
				if (status.rem_done) begin
					state_next = ST_READ_P1;
				end
			end
			ST_READ_P1: state_next = ST_READ_P2;
			ST_READ_P2: state_next = ST_READ_B;
			ST_READ_B: state_next = ST_PICK_MUL;
			ST_PICK_MUL: state_next = ST_PICK;
			ST_PICK: state_next = ST_BODY_MUL;
			ST_BODY_MUL: state_next = ST_SUM;
			ST_SUM: state_next = ST_OUT_MUL;
			ST_OUT_MUL: state_next = ST_OUT;
			ST_OUT: begin
				if (status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		op = OP_NONE;
		case (state_q)
			ST_CLEAR: op = OP_CLEAR;
			ST_IDLE: begin
				in_ready = 1'b1;
				op = in_valid ? OP_CAPTURE : OP_NONE;
			end
			ST_LOAD: op = OP_LOAD;
			ST_READ_X: op = OP_READ_X;
			ST_DAMP_MUL: op = OP_DAMP_MUL;
			ST_DAMP: op = OP_DAMP;
			ST_DECAY_MUL: op = OP_DECAY_MUL;
			ST_DECAY: op = OP_DECAY;
			ST_AP1_MUL: op = OP_AP1_MUL;
			ST_AP1: op = OP_AP1;
			ST_AP2_MUL: op = OP_AP2_MUL;
			ST_AP2: op = OP_AP2;
			ST_WRITE: op = OP_WRITE;
			ST_READ_P1: op = OP_READ_P1;
			ST_READ_P2: op = OP_READ_P2;
			ST_READ_B: op = OP_READ_B;
			ST_PICK_MUL: op = OP_PICK_MUL;
			ST_PICK: op = OP_PICK;
			ST_BODY_MUL: op = OP_BODY_MUL;
			ST_SUM: op = OP_SUM;
			ST_OUT_MUL: op = OP_OUT_MUL;
			ST_OUT: op = status.out_free ? OP_OUT : OP_NONE;
			default: op = OP_NONE;
		endcase
	end

endmodule

// File: rtl/core/plucked_string_waveguide_core.sv
// tick: the word is taken in IDLE, the result is registered in OUT once the output is free,
// and only then is the next word taken; the 13-step pickup offset modulo runs beside the
// loop filter, WRITE waits for it; the rest is one shared 34x18 multiplier and one store port
// load: the word is captured, then written to the store in LOAD, no result
// reset: asynchronous, then a clearing pass zeroes the whole delay store before the first word
module plucked_string_waveguide_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [pswg_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // load_position, excitation
	input  logic                                  s_axis_tuser,  // action
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [pswg_pkg::SAMPLE_W-1:0]         m_axis_tdata,  // out_sample
	input  logic                                  cfg_we,
	input  logic [pswg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [pswg_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import pswg_pkg::*;

	op_t        op;
	dp_status_t status;

	pswg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser),
		.status    (status),
		.in_ready  (s_axis_tready),
		.op        (op)
	);

	pswg_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.in_data    (s_axis_tdata[IN_USED_W-1:0]),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_sample (m_axis_tdata),
		.status     (status)
	);

endmodule
